/* design/whp_pkg.sv */
// ----------------------------------------------------------------------------
// whp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package whp_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC     = 4'd0,
    PH_RIFFSIZE  = 4'd1,
    PH_WAVEFMT   = 4'd2,
    PH_FMTLEN    = 4'd3,
    PH_TAG       = 4'd4,
    PH_CHANNELS  = 4'd5,
    PH_RATE      = 4'd6,
    PH_AVG       = 4'd7,
    PH_ALIGN     = 4'd8,
    PH_BITS      = 4'd9,
    PH_FMTSKIP   = 4'd10,
    PH_CHUNKID   = 4'd11,
    PH_CHUNKLEN  = 4'd12,
    PH_CHUNKSKIP = 4'd13,
    PH_DONE      = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BROKEN = 2'd1,
    ST_BADFMT = 2'd2
  } status_e;

  localparam logic [31:0] MinFmtLen = 32'd16;

  localparam logic [7:0] RiffMagic [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WaveFmtSig [8] =
    '{8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6D, 8'h74, 8'h20};
  localparam logic [7:0] DataSig [4] = '{8'h64, 8'h61, 8'h74, 8'h61};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       stream_end;
  } whp_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] format_tag;
    logic [1:0]  channel_count;
    logic [30:0] sample_rate;
    logic [15:0] sample_bits;
    logic [30:0] data_length;
  } whp_result_t;

  // expected signature byte for the compare phases
  function automatic logic [7:0] sig_byte(phase_e ph, logic [2:0] idx);
    logic [7:0] res;
    case (ph)
      PH_MAGIC:   res = RiffMagic[idx[1:0]];
      PH_WAVEFMT: res = WaveFmtSig[idx];
      PH_CHUNKID: res = DataSig[idx[1:0]];
      default:    res = 8'h00;
    endcase
    return res;
  endfunction

  // number of bytes in the field read during a phase
  function automatic logic [3:0] field_len(phase_e ph);
    logic [3:0] res;
    case (ph)
      PH_WAVEFMT:                                    res = 4'd8;
      PH_TAG, PH_CHANNELS, PH_ALIGN, PH_BITS:        res = 4'd2;
      PH_FMTSKIP, PH_CHUNKSKIP, PH_DONE:             res = 4'd1;
      default:                                       res = 4'd4;
    endcase
    return res;
  endfunction

endpackage

/* design/whp_in_if.sv */
// ----------------------------------------------------------------------------
// whp_in_if
// Byte request channel into the WAV header parser.
// ----------------------------------------------------------------------------
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       stream_end;

  modport source (output valid, data_byte, start_of_file, stream_end, input ready);
  modport sink   (input valid, data_byte, start_of_file, stream_end, output ready);
endinterface

/* design/whp_out_if.sv */
// ----------------------------------------------------------------------------
// whp_out_if
// Result channel out of the WAV header parser.
// ----------------------------------------------------------------------------
interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] format_tag;
  logic [1:0]  channel_count;
  logic [30:0] sample_rate;
  logic [15:0] sample_bits;
  logic [30:0] data_length;

  modport source (output valid, status, format_tag, channel_count, sample_rate,
                  sample_bits, data_length, input ready);
  modport sink   (input valid, status, format_tag, channel_count, sample_rate,
                  sample_bits, data_length, output ready);
endinterface

/* design/whp_parser.sv */
// ----------------------------------------------------------------------------
// whp_parser
// Parse state machine: consumes one request per step and flags the result.
// ----------------------------------------------------------------------------
module whp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  whp_pkg::whp_item_t    item_i,
  output logic                  emit_o,
  output whp_pkg::whp_result_t  result_o
);
  import whp_pkg::*;

  phase_e      phase_q, phase_d, cur_phase;
  logic [2:0]  idx_q, idx_d, cur_idx;
  logic [31:0] acc_q, acc_d, cur_acc;
  logic [31:0] skip_q, skip_d, cur_skip;
  logic [15:0] tag_q, tag_d, cur_tag;
  logic [1:0]  ch_q, ch_d, cur_ch;
  logic [30:0] rate_q, rate_d, cur_rate;
  logic [15:0] bits_q, bits_d, cur_bits;
  logic        isdata_q, isdata_d, cur_isdata;

  logic [31:0] gather_acc, cmp_acc, skip_dec;
  logic        last;
  status_e     status;
  logic [30:0] len;

  always_comb begin
    // a start mark restarts the parser before this byte is handled
    if (item_i.start_of_file) begin
      cur_phase = PH_MAGIC; cur_idx = '0; cur_acc = '0; cur_skip = '0;
      cur_tag = '0; cur_ch = '0; cur_rate = '0; cur_bits = '0; cur_isdata = 1'b0;
    end else begin
      cur_phase = phase_q; cur_idx = idx_q; cur_acc = acc_q; cur_skip = skip_q;
      cur_tag = tag_q; cur_ch = ch_q; cur_rate = rate_q; cur_bits = bits_q;
      cur_isdata = isdata_q;
    end

    gather_acc = cur_acc | ({24'd0, item_i.data_byte} << {cur_idx[1:0], 3'b000});
    cmp_acc    = cur_acc | {24'd0, item_i.data_byte ^ sig_byte(cur_phase, cur_idx)};
    last       = ({1'b0, cur_idx} + 4'd1) >= field_len(cur_phase);
    skip_d     = cur_skip;
    skip_dec   = (cur_skip != '0) ? cur_skip - 32'd1 : cur_skip;

    phase_d = cur_phase; idx_d = cur_idx + 3'd1; acc_d = cur_acc;
    tag_d = cur_tag; ch_d = cur_ch; rate_d = cur_rate; bits_d = cur_bits;
    isdata_d = cur_isdata;
    emit_o = 1'b0; status = ST_OK; len = '0;

    if (cur_phase == PH_DONE) begin
      idx_d = cur_idx;
    end else if (item_i.stream_end) begin
      emit_o = 1'b1; status = ST_BROKEN;
    end else begin
      case (cur_phase)
        PH_MAGIC, PH_WAVEFMT: begin
          acc_d = cmp_acc;
          if (last) begin
            if (cmp_acc != '0) begin
              emit_o = 1'b1; status = ST_BADFMT;
            end else begin
              phase_d = (cur_phase == PH_MAGIC) ? PH_RIFFSIZE : PH_FMTLEN;
            end
          end
        end
        PH_CHUNKID: begin
          acc_d = cmp_acc;
          if (last) begin
            isdata_d = (cmp_acc == '0);
            phase_d  = PH_CHUNKLEN;
          end
        end
        PH_RIFFSIZE, PH_AVG, PH_ALIGN, PH_TAG, PH_BITS: begin
          acc_d = gather_acc;
          if (last) begin
            case (cur_phase)
              PH_RIFFSIZE: phase_d = PH_WAVEFMT;
              PH_AVG:      phase_d = PH_ALIGN;
              PH_ALIGN:    phase_d = PH_BITS;
              PH_TAG: begin
                tag_d   = gather_acc[15:0];
                phase_d = PH_CHANNELS;
              end
              default: begin
                bits_d  = gather_acc[15:0];
                phase_d = (cur_skip == '0) ? PH_CHUNKID : PH_FMTSKIP;
              end
            endcase
          end
        end
        PH_FMTLEN: begin
          acc_d = gather_acc;
          if (last) begin
            if (gather_acc[31] || gather_acc < MinFmtLen) begin
              emit_o = 1'b1; status = ST_BROKEN;
            end else begin
              skip_d  = gather_acc - MinFmtLen;
              phase_d = PH_TAG;
            end
          end
        end
        PH_CHANNELS: begin
          acc_d = gather_acc;
          if (last) begin
            if (gather_acc != 32'd1 && gather_acc != 32'd2) begin
              emit_o = 1'b1; status = ST_BADFMT;
            end else begin
              ch_d    = gather_acc[1:0];
              phase_d = PH_RATE;
            end
          end
        end
        PH_RATE: begin
          acc_d = gather_acc;
          if (last) begin
            if (gather_acc[31]) begin
              emit_o = 1'b1; status = ST_BROKEN;
            end else begin
              rate_d  = gather_acc[30:0];
              phase_d = PH_AVG;
            end
          end
        end
        PH_FMTSKIP, PH_CHUNKSKIP: begin
          idx_d  = cur_idx;
          skip_d = skip_dec;
          if (skip_dec == '0) phase_d = PH_CHUNKID;
        end
        PH_CHUNKLEN: begin
          acc_d = gather_acc;
          if (last) begin
            if (gather_acc[31]) begin
              emit_o = 1'b1; status = ST_BROKEN;
            end else if (cur_isdata) begin
              emit_o = 1'b1; status = ST_OK; len = gather_acc[30:0];
            end else begin
              skip_d  = gather_acc;
              phase_d = (gather_acc == '0) ? PH_CHUNKID : PH_CHUNKSKIP;
            end
          end
        end
        default: begin
          idx_d = cur_idx;
        end
      endcase
    end

    // any phase change restarts the byte count and accumulator
    if (emit_o) phase_d = PH_DONE;
    if (phase_d != cur_phase || emit_o) begin
      idx_d = '0;
      acc_d = '0;
    end

    result_o.status        = status;
    result_o.format_tag    = cur_tag;
    result_o.channel_count = cur_ch;
    result_o.sample_rate   = cur_rate;
    result_o.sample_bits   = cur_bits;
    result_o.data_length   = len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      idx_q    <= '0;
      acc_q    <= '0;
      skip_q   <= '0;
      tag_q    <= '0;
      ch_q     <= '0;
      rate_q   <= '0;
      bits_q   <= '0;
      isdata_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      acc_q    <= acc_d;
      skip_q   <= skip_d;
      tag_q    <= tag_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      bits_q   <= bits_d;
      isdata_q <= isdata_d;
    end
  end

endmodule

/* design/wav_header_parser.sv */
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE header parser, one file byte per request, one result per file.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  in_i    | in  | data_byte, start_of_file, stream_end            | valid/ready
//  out_o   | out | status, format_tag, channel_count, sample_rate, | valid/ready
//          |     | sample_bits, data_length                        |
//
//  one request per cycle while out_o is not stalled; a result leaves from the result register
//  the result is formed from the input register into the result register
//  stalls on out_o back up through the input register to in_i.ready
//  reset returns the parser to waiting for the RIFF magic
// ----------------------------------------------------------------------------
module wav_header_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  whp_in_if.sink    in_i,
  whp_out_if.source out_o
);
  import whp_pkg::*;

  logic        in_valid_q;
  whp_item_t   in_q;
  logic        out_valid_q;
  whp_result_t out_q;
  logic        advance;
  logic        emit;
  whp_result_t result;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;

  whp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_valid_q && advance),
    .item_i   (in_q),
    .emit_o   (emit),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.data_byte     <= in_i.data_byte;
      in_q.start_of_file <= in_i.start_of_file;
      in_q.stream_end    <= in_i.stream_end;
    end
    if (advance && in_valid_q && emit) out_q <= result;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.format_tag    = out_q.format_tag;
  assign out_o.channel_count = out_q.channel_count;
  assign out_o.sample_rate   = out_q.sample_rate;
  assign out_o.sample_bits   = out_q.sample_bits;
  assign out_o.data_length   = out_q.data_length;

endmodule
